@@ src/eds_pkg.sv @@
// Package for the error diffusion spreader: constants, codes, weight table.
// Used by eds_front, eds_back, the top and the checker; depends on nothing.
package eds_pkg;

	localparam int MaxWidth = 4096;
	localparam int ColW = $clog2(MaxWidth);
	localparam int AccW = 24;
	localparam int ErrW = 20;
	localparam int NumTaps = 12;
	localparam int TapW = 4;
	localparam int QueueDepth = 2;

	typedef enum logic [1:0] {
		OP_DIFFUSE = 2'd0,
		OP_READ    = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	localparam logic CFG_MATRIX = 1'b0;
	localparam logic CFG_WIDTH  = 1'b1;

	// Work word handed from front to back.
	typedef struct packed {
		op_t                       op;
		logic signed [ErrW-1:0]    err;
		logic [ColW-1:0]           col;
		logic                      odd;
		logic [2:0]                sel;
		logic [ColW:0]             width;
	} work_t;

	function automatic logic [15:0] weight(input logic [2:0] sel, input logic [TapW-1:0] t);
		logic [15:0] w [8][12];
		w[0] = '{16'd28672,16'd0,16'd0,16'd12288,16'd20480,16'd4096,16'd0,16'd0,16'd0,16'd0,16'd0,16'd0};
		w[1] = '{16'd9557,16'd6827,16'd4096,16'd6827,16'd9557,16'd6827,16'd4096,16'd1365,16'd4096,16'd6827,16'd4096,16'd1365};
		w[2] = '{16'd12483,16'd6242,16'd3121,16'd6242,16'd12483,16'd6242,16'd3121,16'd1560,16'd3121,16'd6242,16'd3121,16'd1560};
		w[3] = '{16'd16384,16'd8192,16'd4096,16'd8192,16'd16384,16'd8192,16'd4096,16'd0,16'd0,16'd0,16'd0,16'd0};
		w[4] = '{16'd10240,16'd6144,16'd4096,16'd8192,16'd10240,16'd8192,16'd4096,16'd0,16'd4096,16'd6144,16'd4096,16'd0};
		w[5] = '{16'd16384,16'd12288,16'd4096,16'd8192,16'd12288,16'd8192,16'd4096,16'd0,16'd0,16'd0,16'd0,16'd0};
		w[6] = '{16'd32768,16'd0,16'd0,16'd16384,16'd16384,16'd0,16'd0,16'd0,16'd0,16'd0,16'd0,16'd0};
		w[7] = '{16'd8192,16'd8192,16'd0,16'd8192,16'd8192,16'd8192,16'd0,16'd0,16'd0,16'd8192,16'd0,16'd0};
		if (t < 4'd12) return w[sel][t];
		return 16'd0;
	endfunction

	function automatic logic [1:0] tap_row(input logic [TapW-1:0] t);
		if (t < 4'd2) return 2'd0;
		if (t < 4'd7) return 2'd1;
		return 2'd2;
	endfunction

	// Signed column offset in scan direction.
	function automatic logic signed [2:0] tap_off(input logic [TapW-1:0] t);
		case (t)
			4'd0, 4'd5, 4'd10: return 3'sd1;
			4'd1, 4'd6, 4'd11: return 3'sd2;
			4'd2, 4'd7:        return -3'sd2;
			4'd3, 4'd8:        return -3'sd1;
			default:           return 3'sd0;
		endcase
	endfunction

endpackage

@@ src/eds_ram.sv @@
// Generic single-port RAM with registered read.
// Standalone; no package needed.
module eds_ram #(
	parameter int Width = 24,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Write through the port; register read data, which shows the old word on a write
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

@@ src/eds_front.sv @@
// Front end: configuration registers, input classification, two-word queue.
// Depends on eds_pkg.
module eds_front
	import eds_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [12:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              opcode,
	input  logic signed [ErrW-1:0]  error_value,
	input  logic [ColW-1:0]         column,
	input  logic                    row_is_odd,
	output logic                    wq_valid,
	output work_t                   wq_word,
	input  logic                    wq_take
);

	logic [3:0]  matrix_q;
	logic [12:0] width_q;
	work_t       queue_q [QueueDepth];
	logic [1:0]  count_q;
	logic        push;
	logic        keep;
	logic        to_head;
	work_t       incoming;

	assign cfg_ready = 1'b1;
	assign in_stall  = (count_q == 2'(QueueDepth));
	assign push      = in_valid && !in_stall;
	// Drop no-ops and out-of-row diffuse words at the door
	assign keep = (opcode != OP_NOP) &&
		!(opcode == OP_DIFFUSE && {1'b0, column} >= incoming.width);
	// New word lands at the head when the queue is empty after this edge
	assign to_head = push && keep && (count_q == 2'd0 || (count_q == 2'd1 && wq_take));

	always_comb begin
		incoming.op    = op_t'(opcode);
		incoming.err   = error_value;
		incoming.col   = column;
		incoming.odd   = row_is_odd;
		incoming.sel   = matrix_q[3] ? 3'd0 : matrix_q[2:0];
		incoming.width = (width_q > 13'(MaxWidth)) ? (ColW+1)'(MaxWidth) : width_q[ColW:0];
	end

	assign wq_valid = (count_q != 2'd0);
	assign wq_word  = queue_q[0];

	// Hold config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= 4'd0;
			width_q  <= 13'(MaxWidth);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MATRIX) matrix_q <= cfg_data[3:0];
			else width_q <= cfg_data;
		end
	end

	// Advance the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + 2'(push && keep) - 2'(wq_take);
		end
	end

	always_ff @(posedge clk) begin
		if (to_head) queue_q[0] <= incoming;
		else if (wq_take) queue_q[0] <= queue_q[1];
		if (push && keep && !to_head) queue_q[1] <= incoming;
	end

endmodule

@@ src/eds_back.sv @@
// Back end: tap sequencer, multiply, saturating read-modify-write, clear pass.
// Depends on eds_pkg and eds_ram.
module eds_back
	import eds_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wq_valid,
	input  work_t                   wq_word,
	output logic                    wq_take,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [AccW-1:0]  error_sum
);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_TAP, ST_MUL, ST_RD, ST_WR, ST_READ, ST_ADV
	} state_t;

	state_t             state_q;
	work_t              w_q;
	logic [TapW-1:0]    tap_q;
	logic [1:0]         rot_q;
	logic [1:0]         clr_bank_q;
	logic [ColW:0]      clr_q;
	logic [1:0]         bank_q;
	logic [ColW-1:0]    addr_q;
	logic signed [ErrW+17:0] prod_q;
	logic signed [ErrW:0]    add_q;
	logic               out_valid_q;
	logic signed [AccW-1:0] out_q;
	logic               rd_pend_q;
	logic               rd_fire;

	logic [ColW-1:0]    ram_addr [3];
	logic               ram_we   [3];
	logic [AccW-1:0]    ram_wd;
	logic [AccW-1:0]    ram_rd   [3];

	// Column of the current tap and its validity
	logic signed [ColW+2:0] tcol;
	logic                   tap_ok;
	logic [2:0]             tsum;
	logic [1:0]             tbank;
	logic [15:0]            tw;
	always_comb begin
		tw = weight(w_q.sel, tap_q);
		tcol = $signed({3'b0, w_q.col}) +
			(w_q.odd ? -(ColW+3)'(tap_off(tap_q)) : (ColW+3)'(tap_off(tap_q)));
		tap_ok = (tw != 16'd0) && (tcol >= 0) &&
			(tcol < $signed({2'b0, w_q.width}));
		tsum = 3'(rot_q) + 3'(tap_row(tap_q));
		tbank = (tsum >= 3'd3) ? 2'(tsum - 3'd3) : tsum[1:0];
	end

	// Round product half toward +inf and saturate the sum
	logic signed [ErrW+17:0] rounded;
	logic signed [AccW:0]    sum;
	logic signed [AccW-1:0]  sat;
	always_comb begin
		rounded = (prod_q + 38'sd32768) >>> 16;
		sum = $signed({ram_rd[bank_q][AccW-1], ram_rd[bank_q]}) + (AccW+1)'(add_q);
		if (sum > (AccW+1)'(25'sd8388607)) sat = 24'sd8388607;
		else if (sum < -(AccW+1)'(25'sd8388608)) sat = -24'sd8388608;
		else sat = sum[AccW-1:0];
		ram_wd = (state_q == ST_CLEAR || state_q == ST_ADV) ? '0 : sat;
	end

	always_comb begin
		for (int b = 0; b < 3; b++) begin
			ram_we[b]   = 1'b0;
			ram_addr[b] = addr_q;
			if ((state_q == ST_CLEAR || state_q == ST_ADV) && 2'(b) == clr_bank_q) begin
				ram_we[b]   = 1'b1;
				ram_addr[b] = clr_q[ColW-1:0];
			end else if (state_q == ST_WR && 2'(b) == bank_q) begin
				ram_we[b] = 1'b1;
			end
		end
	end

	for (genvar b = 0; b < 3; b++) begin : g_bank
		eds_ram #(.Width(AccW), .Depth(MaxWidth)) u_ram (
			.clk(clk), .we(ram_we[b]), .addr(ram_addr[b]),
			.wdata(ram_wd), .rdata(ram_rd[b])
		);
	end

	assign wq_take   = (state_q == ST_IDLE) && wq_valid;
	assign out_valid = out_valid_q;
	assign error_sum = out_q;
	// Read data is ready and the output register is free
	assign rd_fire   = (state_q == ST_READ) && rd_pend_q && (!out_valid_q || !out_stall);

	// Sequence taps, reads and clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rot_q       <= 2'd0;
			clr_bank_q  <= 2'd0;
			clr_q       <= '0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			if (rd_fire) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_q[ColW-1:0] == ColW'(MaxWidth - 1)) begin
						clr_q <= '0;
						if (clr_bank_q == 2'd2) begin
							clr_bank_q <= 2'd0;
							state_q    <= ST_IDLE;
						end else clr_bank_q <= clr_bank_q + 2'd1;
					end else clr_q <= clr_q + (ColW+1)'(1);
				end
				ST_IDLE: begin
					if (wq_valid) begin
						w_q   <= wq_word;
						tap_q <= '0;
						case (wq_word.op)
							OP_DIFFUSE: state_q <= ST_TAP;
							OP_READ: begin
								addr_q    <= wq_word.col;
								bank_q    <= rot_q;
								rd_pend_q <= 1'b0;
								state_q   <= ST_READ;
							end
							OP_ADVANCE: begin
								clr_bank_q <= rot_q;
								clr_q      <= '0;
								state_q    <= ST_ADV;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_TAP: begin
					if (tap_q == TapW'(NumTaps)) state_q <= ST_IDLE;
					else if (tap_ok) begin
						prod_q  <= (ErrW+18)'(w_q.err) * $signed({1'b0, tw});
						addr_q  <= tcol[ColW-1:0];
						bank_q  <= tbank;
						state_q <= ST_MUL;
					end else tap_q <= tap_q + TapW'(1);
				end
				ST_MUL: begin
					add_q   <= rounded[ErrW:0];
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					tap_q   <= tap_q + TapW'(1);
					state_q <= ST_TAP;
				end
				ST_READ: begin
					if (!rd_pend_q) rd_pend_q <= 1'b1;
					else if (rd_fire) begin
						out_q   <= ram_rd[bank_q];
						state_q <= ST_IDLE;
					end
				end
				ST_ADV: begin
					if (clr_q[ColW-1:0] == ColW'(MaxWidth - 1)) begin
						rot_q   <= (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
						state_q <= ST_IDLE;
					end else clr_q <= clr_q + (ColW+1)'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ src/error_diffusion_spreader.sv @@
// Error diffusion spreader top level: front queue plus back sequencer.
// Depends on eds_pkg, eds_front, eds_back.
//
// Usage: input words (opcode, error_value, column, row_is_odd) arrive on a
// valid/stall channel. Opcode 0 spreads the error into three row banks
// with the weight set in register 0; opcode 1 returns the current-row sum
// at column on the output valid/stall channel; opcode 2 clears the current
// row and rotates rows; opcode 3 is dropped. Register 0 selects the weight
// set, register 1 the row width, over a valid/ready write channel.
// Work: a diffuse word is taken in idle, then every weight slot is checked and
// each tap taken runs its multiply, RAM read and RAM write steps in turn, bound
// by the single read-modify-write port per bank. A read waits for registered RAM
// data and a free output register; an advance clears one bank entry per cycle.
// Reset clears all three banks in one pass; words queue in the front
// meanwhile. A stalled result holds; a further read waits on it in the back,
// while the two-word front queue accepts words until it is full.
module error_diffusion_spreader
	import eds_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [12:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              opcode,
	input  logic signed [ErrW-1:0]  error_value,
	input  logic [ColW-1:0]         column,
	input  logic                    row_is_odd,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [AccW-1:0]  error_sum
);

	logic  wq_valid;
	logic  wq_take;
	work_t wq_word;

	eds_front u_front (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .opcode, .error_value, .column, .row_is_odd,
		.wq_valid, .wq_word, .wq_take
	);

	eds_back u_back (
		.clk, .arst_n, .wq_valid, .wq_word, .wq_take,
		.out_valid, .out_stall, .error_sum
	);

endmodule

@@ src/eds_checker.sv @@
// Port-level checker for the error diffusion spreader, bound to the top.
// Depends on eds_pkg.
module eds_checker
	import eds_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_stall,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic signed [AccW-1:0] error_sum,
	input  logic                   cfg_ready
);

	// A stalled result word holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(error_sum))
		else $error("result word changed under stall");

	// Configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

	// No result comes out of reset by itself
	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result right after reset");

	// Input stall is always driven to a known level
	a_stall_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(in_stall))
		else $error("input stall unknown");

endmodule

bind error_diffusion_spreader eds_checker u_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .error_sum, .cfg_ready
);

@@ sim/error_diffusion_spreader_tb.sv @@
// Self-checking bench for the serpentine error-diffusion spreader.
// Models the three row banks, sends diffuse/read/advance words and checks reads.
// Depends on eds_pkg and error_diffusion_spreader.
module error_diffusion_spreader_tb;
	import eds_pkg::*;

	localparam int AccMax = 8388607;
	localparam int AccMin = -8388608;
	localparam longint CycleLimit = 4000000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [12:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] opcode;
	logic signed [ErrW-1:0] error_value;
	logic [ColW-1:0] column;
	logic row_is_odd;
	logic out_valid;
	logic out_stall;
	logic signed [AccW-1:0] error_sum;

	// Shadow of the row banks and configuration
	int bank_acc [3][MaxWidth];
	int cur_bank;
	int sel_shadow;
	int width_shadow;
	logic signed [AccW-1:0] sum_queue [$];

	int mismatches;
	int reads_checked;
	int sends;
	longint cycles;
	int idle_pct;
	bit hold_off;

	error_diffusion_spreader u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .error_value(error_value),
		.column(column), .row_is_odd(row_is_odd),
		.out_valid(out_valid), .out_stall(out_stall), .error_sum(error_sum)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Weighted error, rounded half toward +infinity
	function automatic int weighted_error(int err, int w);
		longint q;
		q = longint'(err) * longint'(w) + 32768;
		return int'(q >>> 16);
	endfunction

	function automatic int tap_weight(int s, int t);
		int wt [8][12];
		wt[0] = '{28672, 0, 0, 12288, 20480, 4096, 0, 0, 0, 0, 0, 0};
		wt[1] = '{9557, 6827, 4096, 6827, 9557, 6827, 4096, 1365, 4096, 6827, 4096, 1365};
		wt[2] = '{12483, 6242, 3121, 6242, 12483, 6242, 3121, 1560, 3121, 6242, 3121, 1560};
		wt[3] = '{16384, 8192, 4096, 8192, 16384, 8192, 4096, 0, 0, 0, 0, 0};
		wt[4] = '{10240, 6144, 4096, 8192, 10240, 8192, 4096, 0, 4096, 6144, 4096, 0};
		wt[5] = '{16384, 12288, 4096, 8192, 12288, 8192, 4096, 0, 0, 0, 0, 0};
		wt[6] = '{32768, 0, 0, 16384, 16384, 0, 0, 0, 0, 0, 0, 0};
		wt[7] = '{8192, 8192, 0, 8192, 8192, 8192, 0, 0, 0, 8192, 0, 0};
		return wt[s][t];
	endfunction

	// Advance the shadow banks for one accepted word
	function automatic void predict_word(op_t op, int err, int col, bit odd);
		int offs [12];
		int rows [12];
		int s, w, c, b, sum, dir, t;
		offs = '{1, 2, -2, -1, 0, 1, 2, -2, -1, 0, 1, 2};
		rows = '{0, 0, 1, 1, 1, 1, 1, 2, 2, 2, 2, 2};
		w = (width_shadow < MaxWidth) ? width_shadow : MaxWidth;
		s = (sel_shadow <= 7) ? sel_shadow : 0;
		dir = odd ? -1 : 1;
		case (op)
			OP_DIFFUSE: begin
				if (col < w) begin
					for (t = 0; t < 12; t++) begin
						c = col + dir * offs[t];
						if (c < 0 || c >= w || tap_weight(s, t) == 0)
							continue;
						b = (cur_bank + rows[t]) % 3;
						sum = bank_acc[b][c] + weighted_error(err, tap_weight(s, t));
						if (sum > AccMax)
							sum = AccMax;
						if (sum < AccMin)
							sum = AccMin;
						bank_acc[b][c] = sum;
					end
				end
			end
			OP_READ: begin
				sum_queue.push_back(AccW'(bank_acc[cur_bank][col]));
			end
			OP_ADVANCE: begin
				for (c = 0; c < MaxWidth; c++)
					bank_acc[cur_bank][c] = 0;
				cur_bank = (cur_bank + 1) % 3;
			end
			default: ;
		endcase
	endfunction

	// Send one word and wait for it to be taken; valid stays up until the next idle
	task automatic send_word(op_t op, int err, int col, bit odd);
		while (($urandom_range(99) < idle_pct) && !hold_off) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		error_value <= ErrW'(err);
		column <= ColW'(col);
		row_is_odd <= odd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_word(op, err, col, odd);
		sends++;
	endtask

	// Drain: wait until every read has returned, then let the block settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (sum_queue.size() != 0)
			@(posedge clk);
		repeat (13000) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 13'(val);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_MATRIX)
			sel_shadow = val & 15;
		else
			width_shadow = val & 13'h1fff;
	endtask

	task automatic set_config(int sel, int wid);
		wait_quiet();
		write_reg(CFG_MATRIX, sel);
		write_reg(CFG_WIDTH, wid);
		cfg_valid <= 1'b0;
	endtask

	function automatic int rand_err();
		case ($urandom_range(5))
			0: return 524287;
			1: return -524288;
			default: return $signed(20'($urandom()));
		endcase
	endfunction

	// Directed: extremes, weight set 0, edges, repeated accumulation, nop, advance
	task automatic test_directed();
		set_config(0, 4096);
		send_word(OP_DIFFUSE, 524287, 0, 1'b0);
		send_word(OP_DIFFUSE, -524288, 4095, 1'b1);
		send_word(OP_READ, 0, 1, 1'b0);
		send_word(OP_READ, 0, 4094, 1'b0);
		send_word(OP_NOP, 12345, 7, 1'b1);
		for (int i = 0; i < 8; i++)
			send_word(OP_DIFFUSE, 524287, 5, 1'b0);
		send_word(OP_READ, 0, 6, 1'b0);
		send_word(OP_ADVANCE, 0, 0, 1'b0);
		send_word(OP_READ, 0, 5, 1'b0);
		send_word(OP_READ, 0, 4095, 1'b1);
		send_word(OP_ADVANCE, 0, 4095, 1'b1);
		send_word(OP_READ, 0, 5, 1'b0);
	endtask

	// Each weight set, with small widths and tap clipping at both ends
	task automatic test_weight_sets();
		for (int s = 0; s < 16; s += (s < 8 ? 1 : 7)) begin
			set_config(s, (s % 3 == 0) ? 1 : 8 + s);
			for (int i = 0; i < 10; i++)
				send_word(OP_DIFFUSE, rand_err(), $urandom_range(18), 1'($urandom()));
			for (int i = 0; i < 4; i++)
				send_word(OP_READ, 0, $urandom_range(18), 1'b0);
			send_word(OP_ADVANCE, 0, 0, 1'b0);
			for (int i = 0; i < 3; i++)
				send_word(OP_READ, 0, $urandom_range(18), 1'b0);
		end
	endtask

	// Random rows: serpentine scans of diffuse words with reads and nops, sometimes then an advance
	task automatic test_random_rows(int words, bit fill);
		int w, col;
		bit odd;
		w = 4 + $urandom_range(20);
		set_config($urandom_range(15), w);
		odd = 0;
		for (int n = 0; n < words; ) begin
			if (fill && n == 20) begin
				hold_off = 1'b1;
				fork
					begin
						for (int k = 0; k < 400; k++)
							@(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			col = odd ? w - 1 : 0;
			for (int k = 0; k < w && n < words; k++, n++) begin
				case ($urandom_range(9))
					0, 1, 2: send_word(OP_READ, 0, $urandom_range(4095), odd);
					3: send_word(OP_NOP, rand_err(), $urandom_range(4095), 1'($urandom()));
					4: send_word(OP_DIFFUSE, rand_err(), $urandom_range(4095), odd);
					default: send_word(OP_DIFFUSE, rand_err(), col, odd);
				endcase
				col += odd ? -1 : 1;
			end
			if ($urandom_range(3) == 0)
				send_word(OP_ADVANCE, 0, $urandom_range(4095), odd);
			odd = ~odd;
		end
	endtask

	// Receive and check reads; stalls at random or during a hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (sum_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected read word: error_sum=%0d", error_sum);
				end else begin
					if (error_sum !== sum_queue[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("error_sum mismatch: expected %0d actual %0d",
								sum_queue[0], error_sum);
					end
					void'(sum_queue.pop_front());
					reads_checked++;
				end
			end
			out_stall <= hold_off || ($urandom_range(99) < idle_pct);
		end
	end

	// Guard against a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_NOP;
		error_value = '0;
		column = '0;
		row_is_odd = 1'b0;
		out_stall = 1'b0;
		mismatches = 0;
		reads_checked = 0;
		sends = 0;
		cycles = 0;
		hold_off = 1'b0;
		idle_pct = 38;
		cur_bank = 0;
		sel_shadow = 0;
		width_shadow = 4096;
		foreach (bank_acc[b, c])
			bank_acc[b][c] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_weight_sets();
		test_random_rows(120, 1'b1);
		idle_pct = 0;
		test_random_rows(150, 1'b0);
		idle_pct = 38;
		test_random_rows(160, 1'b0);
		test_random_rows(150, 1'b0);
		wait_quiet();
		$display("Sent %0d words over all weight sets and widths 1..4096; %0d reads checked.",
			sends, reads_checked);
		if (mismatches == 0 && sum_queue.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
